// ----- design/llf_pkg.sv -----
package llf_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int STATE_WIDTH_DEF  = 24;

	// configuration port
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 1'b1;
	localparam logic [CFG_W-1:0]     CUTOFF_RST    = 15'd26214;
	localparam logic [CFG_W-1:0]     RESONANCE_RST = 15'd0;

	// fixed coefficients
	localparam int C_POINT8 = 26214; // 0.8 in Q0.15
	localparam int C_FIVE6  = 45875; // 5.6 in Q3.13
	localparam int C_SIXTH  = 5461;  // 1/6 in Q0.15
	localparam int C_ONE15  = 32768; // 1.0 in Q.15

	// one entry per product of the per-sample schedule
	typedef enum logic [4:0] {
		STP_P,
		STP_PC,
		STP_Q0SQ,
		STP_INNER,
		STP_G,
		STP_K,
		STP_KS,
		STP_S1A,
		STP_S1B,
		STP_S2A,
		STP_S2B,
		STP_S3A,
		STP_S3B,
		STP_S4A,
		STP_S4B,
		STP_SQ,
		STP_CU,
		STP_TH
	} step_t;

	typedef struct packed {
		logic  start;
		logic  load;
		logic  mul;
		logic  wb;
		logic  out_load;
		step_t step;
	} ctrl_t;

	// fraction bits used for the cube
	function automatic int cube_frac(input int sw);
		return (sw - 4 > 24) ? 24 : sw - 4;
	endfunction

	function automatic int mul_a_w(input int sw);
		return sw + 8;
	endfunction

	function automatic int mul_b_w(input int sw);
		int aw;
		aw = sw - (sw - 4 - cube_frac(sw)) + 1;
		return (aw > 17) ? aw : 17;
	endfunction

endpackage

// ----- design/llf_mul.sv -----
module llf_mul #(
	parameter int A_W = 31,
	parameter int B_W = 25
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] prod
);

	logic signed [A_W+B_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

// ----- design/llf_ctrl.sv -----
module llf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output llf_pkg::ctrl_t ctrl
);
	import llf_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		LOAD,
		MUL,
		WB,
		OUT
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= STP_P;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid with a new sample, drop it after a transfer
			if (state_q == OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= LOAD;
						step_q  <= STP_P;
					end
				end
				LOAD: state_q <= MUL;
				MUL:  state_q <= WB;
				WB: begin
					if (step_q == STP_TH) begin
						state_q <= OUT;
					end else begin
						step_q  <= step_t'(step_q + 5'd1);
						state_q <= LOAD;
					end
				end
				OUT: begin
					// hold the finished sample until the output slot frees up
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == IDLE);
	assign out_valid     = out_valid_q;
	assign ctrl.start    = (state_q == IDLE) && in_valid;
	assign ctrl.load     = (state_q == LOAD);
	assign ctrl.mul      = (state_q == MUL);
	assign ctrl.wb       = (state_q == WB);
	assign ctrl.out_load = (state_q == OUT) && out_free;
	assign ctrl.step     = step_q;

endmodule

// ----- design/llf_dpath.sv -----
module llf_dpath #(
	parameter int SAMPLE_WIDTH = llf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = llf_pkg::STATE_WIDTH_DEF,
	parameter int A_W          = llf_pkg::mul_a_w(STATE_WIDTH),
	parameter int B_W          = llf_pkg::mul_b_w(STATE_WIDTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  llf_pkg::ctrl_t                    ctrl,
	input  logic                              cfg_wr_en,
	input  logic [llf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [llf_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
	output logic signed [A_W-1:0]             opa,
	output logic signed [B_W-1:0]             opb,
	input  logic signed [A_W+B_W-1:0]         prod,
	output logic signed [SAMPLE_WIDTH-1:0]    sample_out
);
	import llf_pkg::*;

	localparam int SW  = STATE_WIDTH;
	localparam int SMW = SAMPLE_WIDTH;
	localparam int SF  = SW - 4;
	localparam int XF  = SMW - 1;
	localparam int CF  = cube_frac(SW);
	localparam int D   = SF - CF;
	localparam int AW  = SW - D + 1;
	localparam int SQW = AW + 4;
	localparam int CUW = AW + 7;
	localparam int PW  = A_W + B_W;
	localparam int XW  = SMW + 1;
	localparam int OW  = (XF > SF) ? (SW + XF - SF + 1) : (SW + 1);

	localparam logic signed [PW-1:0] ST_MAX  = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [PW-1:0] ST_MIN  = ~ST_MAX;
	localparam logic signed [OW-1:0] OUT_MAX = {{(OW-SMW+1){1'b0}}, {(SMW-1){1'b1}}};
	localparam logic signed [OW-1:0] OUT_MIN = ~OUT_MAX;

	// config and filter state
	logic [CFG_W-1:0]         cutoff_q;
	logic [CFG_W-1:0]         resonance_q;
	logic signed [SW-1:0]     hold_q;
	logic signed [SW-1:0]     st1_q;
	logic signed [SW-1:0]     st2_q;
	logic signed [SW-1:0]     st3_q;
	logic signed [SW-1:0]     st4_q;

	// per-sample working registers
	logic signed [SW-1:0]     x_q;
	logic signed [SW-1:0]     v_q;
	logic signed [SW-1:0]     t1_q;
	logic signed [SW-1:0]     t2_q;
	logic signed [PW-1:0]     acc_q;
	logic [13:0]              p_q;
	logic [14:0]              pc_q;
	logic [15:0]              q0sq_q;
	logic [17:0]              inner_q;
	logic [16:0]              g_q;
	logic [15:0]              k_q;
	logic signed [SQW-1:0]    sq_q;
	logic signed [CUW-1:0]    cube_q;
	logic signed [A_W-1:0]    opa_q;
	logic signed [B_W-1:0]    opb_q;
	logic signed [SMW-1:0]    out_q;

	logic signed [A_W-1:0]    opa_d;
	logic signed [B_W-1:0]    opb_d;
	logic [15:0]              q0;
	logic signed [16:0]       f_val;
	logic signed [AW-1:0]     a_val;
	logic signed [SW-1:0]     x_ext;
	logic signed [OW-1:0]     y_wide;
	logic signed [SMW-1:0]    y_sat;

	function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v, input int s);
		return (v + (PW'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [SW-1:0] sat_st(input logic signed [PW-1:0] v);
		if (v > ST_MAX) begin
			return ST_MAX[SW-1:0];
		end else if (v < ST_MIN) begin
			return ST_MIN[SW-1:0];
		end
		return v[SW-1:0];
	endfunction

	assign q0    = 16'h8000 - {1'b0, cutoff_q};
	assign f_val = signed'({1'b0, pc_q, 1'b0}) - 17'sd16384;

	generate
		if (D == 0) begin : g_cube_in_full
			assign a_val = AW'(st4_q);
		end else begin : g_cube_in_rnd
			assign a_val = AW'(rnd(PW'(st4_q), D));
		end

		if (SF >= XF) begin : g_in_up
			assign x_ext = SW'(sample_in) <<< (SF - XF);
		end else begin : g_in_down
			assign x_ext = SW'((XW'(sample_in) + (XW'(1) <<< (XF - SF - 1))) >>> (XF - SF));
		end

		if (XF >= SF) begin : g_out_up
			assign y_wide = OW'(st4_q) <<< (XF - SF);
		end else begin : g_out_down
			assign y_wide = (OW'(st4_q) + (OW'(1) <<< (SF - XF - 1))) >>> (SF - XF);
		end
	endgenerate

	always_comb begin
		if (y_wide > OUT_MAX) begin
			y_sat = OUT_MAX[SMW-1:0];
		end else if (y_wide < OUT_MIN) begin
			y_sat = OUT_MIN[SMW-1:0];
		end else begin
			y_sat = y_wide[SMW-1:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		opa_d = '0;
		opb_d = '0;
		unique case (ctrl.step)
			STP_P: begin
				opa_d = A_W'(signed'({1'b0, cutoff_q}));
				opb_d = B_W'(signed'({1'b0, q0}));
			end
			STP_PC: begin
				opa_d = A_W'(signed'({1'b0, p_q}));
				opb_d = B_W'(C_POINT8);
			end
			STP_Q0SQ: begin
				opa_d = A_W'(signed'({1'b0, q0}));
				opb_d = B_W'(signed'({1'b0, q0}));
			end
			STP_INNER: begin
				opa_d = A_W'(signed'({1'b0, q0sq_q}));
				opb_d = B_W'(C_FIVE6);
			end
			STP_G: begin
				opa_d = A_W'(signed'({1'b0, inner_q}));
				opb_d = B_W'(signed'({1'b0, q0}));
			end
			STP_K: begin
				opa_d = A_W'(signed'({1'b0, g_q}));
				opb_d = B_W'(signed'({1'b0, resonance_q}));
			end
			STP_KS: begin
				opa_d = A_W'(st4_q);
				opb_d = B_W'(signed'({1'b0, k_q}));
			end
			STP_S1A: begin
				opa_d = A_W'(v_q) + A_W'(hold_q);
				opb_d = B_W'(signed'({1'b0, pc_q}));
			end
			STP_S1B: begin
				opa_d = A_W'(st1_q);
				opb_d = B_W'(f_val);
			end
			STP_S2A: begin
				opa_d = A_W'(st1_q) + A_W'(t1_q);
				opb_d = B_W'(signed'({1'b0, pc_q}));
			end
			STP_S2B: begin
				opa_d = A_W'(st2_q);
				opb_d = B_W'(f_val);
			end
			STP_S3A: begin
				opa_d = A_W'(st2_q) + A_W'(t2_q);
				opb_d = B_W'(signed'({1'b0, pc_q}));
			end
			STP_S3B: begin
				opa_d = A_W'(st3_q);
				opb_d = B_W'(f_val);
			end
			STP_S4A: begin
				opa_d = A_W'(st3_q) + A_W'(t1_q);
				opb_d = B_W'(signed'({1'b0, pc_q}));
			end
			STP_S4B: begin
				opa_d = A_W'(st4_q);
				opb_d = B_W'(f_val);
			end
			STP_SQ: begin
				opa_d = A_W'(a_val);
				opb_d = B_W'(a_val);
			end
			STP_CU: begin
				opa_d = A_W'(sq_q);
				opb_d = B_W'(a_val);
			end
			STP_TH: begin
				opa_d = A_W'(cube_q);
				opb_d = B_W'(C_SIXTH);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q    <= CUTOFF_RST;
			resonance_q <= RESONANCE_RST;
			hold_q      <= '0;
			st1_q       <= '0;
			st2_q       <= '0;
			st3_q       <= '0;
			st4_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_CUTOFF:    cutoff_q    <= cfg_wdata;
					REG_RESONANCE: resonance_q <= cfg_wdata;
				endcase
			end
			if (ctrl.wb) begin
				case (ctrl.step)
					STP_S1B: st1_q <= sat_st(rnd(acc_q - prod, 14));
					STP_S2B: st2_q <= sat_st(rnd(acc_q - prod, 14));
					STP_S3B: st3_q <= sat_st(rnd(acc_q - prod, 14));
					STP_S4B: st4_q <= sat_st(rnd(acc_q - prod, 14));
					STP_TH: begin
						st4_q  <= sat_st(PW'(st4_q) - (rnd(prod, 15) <<< D));
						hold_q <= v_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= x_ext;
		end
		if (ctrl.load) begin
			opa_q <= opa_d;
			opb_q <= opb_d;
		end
		if (ctrl.out_load) begin
			out_q <= y_sat;
		end
		if (ctrl.wb) begin
			case (ctrl.step) inside
				STP_P:     p_q     <= 14'(rnd(prod, 15));
				STP_PC:    pc_q    <= 15'(rnd(PW'(signed'({1'b0, cutoff_q})) + rnd(prod, 15), 1));
				STP_Q0SQ:  q0sq_q  <= 16'(rnd(prod, 15));
				STP_INNER: inner_q <= 18'(PW'(signed'({1'b0, cutoff_q})) + rnd(prod, 13));
				STP_G:     g_q     <= 17'(PW'(C_ONE15) + rnd(prod, 16));
				STP_K:     k_q     <= 16'(rnd(rnd(prod, 15), 1));
				STP_KS:    v_q     <= sat_st(PW'(x_q) - rnd(prod, 14));
				STP_S1A, STP_S2A, STP_S3A, STP_S4A: acc_q <= prod;
				STP_S1B:   t1_q    <= st1_q;
				STP_S2B:   t2_q    <= st2_q;
				STP_S3B:   t1_q    <= st3_q;
				STP_SQ:    sq_q    <= SQW'(rnd(prod, CF));
				STP_CU:    cube_q  <= CUW'(rnd(prod, CF));
				default: ;
			endcase
		end
	end

	assign opa        = opa_q;
	assign opb        = opb_q;
	assign sample_out = out_q;

endmodule

// ----- design/ladder_lowpass_filter_unit.sv -----
// Channel   Signals                          Dir  Moves
// input     in_valid / in_ready, sample_in   in   one Q1.15 sample per transfer
// output    out_valid / out_ready, sample_out out  one filtered sample per transfer
// config    cfg_wr_en, cfg_index, cfg_wdata  in   0 = cutoff, 1 = resonance
//
// Each sample runs from its transfer to the earliest next one as follows: 18 products
// run one after another through the single shared multiplier, each as operand load,
// multiply and write-back, then the output register is loaded and the sequencer goes
// back to idle. in_ready is high only between samples.
// arst_n clears the stage values, the input hold and the output valid, and sets the
// registers to cutoff 0.8 and resonance 0. A stalled output holds its sample; the
// block still takes the next sample and waits at the end until the output slot frees.
module ladder_lowpass_filter_unit #(
	parameter int SAMPLE_WIDTH = llf_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH  = llf_pkg::STATE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_wr_en,
	input  logic [llf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [llf_pkg::CFG_W-1:0]      cfg_wdata
);
	import llf_pkg::*;

	// multiplier operand widths follow from the state width
	localparam int MUL_A_W = mul_a_w(STATE_WIDTH);
	localparam int MUL_B_W = mul_b_w(STATE_WIDTH);

	ctrl_t                            ctrl;
	logic signed [MUL_A_W-1:0]        opa;
	logic signed [MUL_B_W-1:0]        opb;
	logic signed [MUL_A_W+MUL_B_W-1:0] prod;

	// sequencer: walks the product schedule and owns both handshakes
	llf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	// registers, operand select, rounding and saturation on write-back
	llf_dpath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.STATE_WIDTH  (STATE_WIDTH),
		.A_W          (MUL_A_W),
		.B_W          (MUL_B_W)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (sample_in),
		.opa        (opa),
		.opb        (opb),
		.prod       (prod),
		.sample_out (sample_out)
	);

	// the one shared multiplier, product registered
	llf_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk  (clk),
		.en   (ctrl.mul),
		.a    (opa),
		.b    (opb),
		.prod (prod)
	);

endmodule

// ----- design/llf_chk.sv -----
module llf_chk #(
	parameter int SAMPLE_WIDTH = llf_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] sample_out
);

	// a transfer in makes the block busy at once
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input transfer");

	// the product schedule keeps the block busy at the checked delay after an input transfer
	a_busy_long: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##20 !in_ready)
		else $error("sample finished too early");

	// a new result only appears at the end of a busy stretch
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2))
		else $error("result appeared without a sample in work");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("stalled output dropped or changed");

endmodule

bind ladder_lowpass_filter_unit llf_chk #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_llf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out)
);

// ----- sim/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import llf_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int ST = STATE_WIDTH_DEF;

	// fraction bits: Q1.15 samples, Q4.20 stages, cube at no more than 24 bits
	localparam int STATE_FRAC  = ST - 4;
	localparam int SAMPLE_FRAC = SW - 1;
	localparam int CUBE_FRAC   = (STATE_FRAC > 24) ? 24 : STATE_FRAC;
	localparam int CUBE_DROP   = STATE_FRAC - CUBE_FRAC;

	// fixed coefficients of the coefficient and clip math
	localparam longint ONE_Q15         = 32768;
	localparam longint ONE_Q14         = 16384;
	localparam longint POINT_EIGHT_Q15 = 26214;
	localparam longint FIVE_SIX_Q13    = 45875;
	localparam longint SIXTH_Q15       = 5461;

	localparam longint STATE_HI = (longint'(1) <<< (ST - 1)) - 1;
	localparam longint STATE_LO = -STATE_HI - 1;
	localparam longint OUT_HI   = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint OUT_LO   = -OUT_HI - 1;

	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 73;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 64;
	localparam int LONG_HOLD       = 400;
	localparam int MAX_PRINTED     = 200;
	localparam int TIMEOUT_NS      = 5_000_000;

	typedef logic signed [SW-1:0] sample_t;
	typedef logic [CFG_W-1:0]     cfg_t;

	localparam sample_t FULL_POS = {1'b0, {(SW-1){1'b1}}};
	localparam sample_t FULL_NEG = {1'b1, {(SW-1){1'b0}}};

	// Tracks the ladder state and register copies, predicts each filtered sample
	// and compares the transfers on the output channel in order.
	class ladder_tracker;
		cfg_t    cutoff_reg;
		cfg_t    resonance_reg;
		longint  hold_in;
		longint  pole1;
		longint  pole2;
		longint  pole3;
		longint  pole4;
		sample_t expected_samples[$];
		int      mismatches;

		function new();
			cutoff_reg    = CUTOFF_RST;
			resonance_reg = RESONANCE_RST;
			hold_in       = 0;
			pole1         = 0;
			pole2         = 0;
			pole3         = 0;
			pole4         = 0;
			mismatches    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, cfg_t val);
			case (idx)
				REG_CUTOFF:    cutoff_reg = val;
				REG_RESONANCE: resonance_reg = val;
				default: ;
			endcase
		endfunction

		// add half an LSB, then floor
		function longint round_shift(longint v, int s);
			if (s <= 0)
				return v;
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function longint ladder_pole(longint a, longint b, longint prev, longint pc, longint f);
			return clamp(round_shift((a + b) * pc - prev * f, 14), STATE_LO, STATE_HI);
		endfunction

		function sample_t filter_sample(sample_t x);
			longint c, r, q0, p, pc, f, q0sq, inner, g, k;
			longint v, old1, old2, old3, a, sq, cube, y;
			c     = longint'(cutoff_reg);
			r     = longint'(resonance_reg);
			q0    = ONE_Q15 - c;
			p     = round_shift(c * q0, 15);
			pc    = round_shift(c + round_shift(POINT_EIGHT_Q15 * p, 15), 1);
			f     = 2 * pc - ONE_Q14;
			q0sq  = round_shift(q0 * q0, 15);
			inner = ONE_Q15 - q0 + round_shift(FIVE_SIX_Q13 * q0sq, 13);
			g     = ONE_Q15 + round_shift(q0 * inner, 16);
			k     = round_shift(round_shift(r * g, 15), 1);

			v = clamp((longint'(x) <<< (STATE_FRAC - SAMPLE_FRAC))
				- round_shift(k * pole4, 14), STATE_LO, STATE_HI);
			old1  = pole1;
			pole1 = ladder_pole(v, hold_in, pole1, pc, f);
			old2  = pole2;
			pole2 = ladder_pole(pole1, old1, pole2, pc, f);
			old3  = pole3;
			pole3 = ladder_pole(pole2, old2, pole3, pc, f);
			pole4 = ladder_pole(pole3, old3, pole4, pc, f);

			a     = round_shift(pole4, CUBE_DROP);
			sq    = round_shift(a * a, CUBE_FRAC);
			cube  = round_shift(a * sq, CUBE_FRAC);
			pole4 = clamp(pole4 - (round_shift(cube * SIXTH_Q15, 15) <<< CUBE_DROP),
				STATE_LO, STATE_HI);
			hold_in = v;

			y = clamp(round_shift(pole4, STATE_FRAC - SAMPLE_FRAC), OUT_LO, OUT_HI);
			return sample_t'(y);
		endfunction

		function void note_sample(sample_t x);
			expected_samples.insert(expected_samples.size(), filter_sample(x));
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		task report_mismatch(string msg);
			if (mismatches < MAX_PRINTED)
				$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_sample(sample_t y);
			sample_t want;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("sample_out %0d with no sample outstanding", y));
				return;
			end
			want = expected_samples.pop_front();
			if (y !== want)
				report_mismatch($sformatf("sample_out %0d, expected %0d", y, want));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	sample_t              sample_in;
	logic                 out_valid;
	logic                 out_ready;
	sample_t              sample_out;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	cfg_t                 cfg_wdata;

	ladder_tracker tracker;

	// idle_on enables random gaps on both channels; hold_requests counts the
	// long hold-offs asked of the receiver, each taken before its next transfer
	bit idle_on;
	int hold_requests;

	ladder_lowpass_filter_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// Sample both channels at the rising edge. Check the output before noting
	// the input so a stray result can never pair with a sample taken this edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_sample(sample_out);
		if (arst_n && in_valid && in_ready)
			tracker.note_sample(sample_in);
	end

	// Receiver: per transfer draw a gap with ready low, then hold ready high
	// until the transfer. Honor a pending long hold-off first, counted here.
	initial begin
		int gap;
		int holds_done;
		holds_done = 0;
		out_ready  = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_requests > holds_done) begin
				holds_done++;
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end
			gap = idle_on ? $urandom_range(0, 13) : 0;
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			@(negedge clk);
		end
	end

	// Offer one sample. Called at a falling edge; returns at the falling edge
	// after the transfer with valid still high, so a back-to-back sample keeps
	// valid up without a drop in between.
	task send_sample(input sample_t x);
		int gap;
		gap = idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		sample_in = x;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted sample has come out, then let the
	// block get back to idle.
	task drain_filter();
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_register(input logic [CFG_IDX_W-1:0] idx, input cfg_t val);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		tracker.set_register(idx, val);
	endtask

	// Registers change only with the filter idle.
	task configure(input cfg_t cut, input cfg_t res);
		drain_filter();
		write_register(REG_CUTOFF, cut);
		write_register(REG_RESONANCE, res);
	endtask

	initial begin
		sample_t x;
		sample_t level;
		cfg_t    cut;
		cfg_t    res;
		int      run_left;
		bit      swing;
		bit      noisy;

		in_valid      = 1'b0;
		sample_in     = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_CUTOFF;
		cfg_wdata     = '0;
		arst_n        = 1'b0;
		idle_on       = 1'b1;
		hold_requests = 0;
		tracker       = new();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset settings, full-scale steps and the smallest values.
		send_sample('0);
		send_sample(FULL_POS);
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
		send_sample(FULL_NEG);
		send_sample(sample_t'(1));
		send_sample(sample_t'(-1));

		// Top cutoff and full resonance: drive the loop into saturation and the
		// output past its range with a full-scale square wave.
		configure('1, '1);
		repeat (3) begin
			send_sample(FULL_POS);
			send_sample(FULL_NEG);
		end

		// Zero cutoff with full resonance.
		configure('0, '1);
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
		send_sample(sample_t'(12345));

		// Top cutoff, no feedback.
		configure('1, '0);
		send_sample(FULL_POS);
		send_sample(FULL_POS);
		send_sample(FULL_NEG);
		send_sample(FULL_NEG);

		// Random phases. Each picks a setting with the extremes well represented,
		// then plays runs of held or alternating levels so the ladder sees step
		// and square responses, mixed with plain noise.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       cut = '0;
				1:       cut = '1;
				default: cut = cfg_t'($urandom);
			endcase
			case ($urandom_range(0, 3))
				0:       res = '0;
				1:       res = '1;
				default: res = cfg_t'($urandom);
			endcase
			configure(cut, res);
			// every third phase runs with no gaps on either side
			idle_on  = (ph % 3 != 2);
			run_left = 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// stall the output long enough that the block fills and
				// blocks its input while samples keep being offered
				if (ph == 3 && n == 20)
					hold_requests++;
				// pause the sender until everything outstanding has come out
				if (ph == 6 && n == 30)
					drain_filter();
				if (run_left == 0) begin
					run_left = $urandom_range(1, 24);
					swing    = ($urandom_range(0, 2) == 0);
					noisy    = 1'b0;
					case ($urandom_range(0, 5))
						0, 1: level = sample_t'($urandom);
						2:    level = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
						3:    level = sample_t'($urandom_range(0, 255) - 128);
						4:    level = '0;
						default: noisy = 1'b1;
					endcase
				end
				x = noisy ? sample_t'($urandom) : level;
				if (swing)
					level = ~level;
				run_left--;
				send_sample(x);
			end
		end

		// Wait out every outstanding sample, then watch for strays.
		drain_filter();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- ladder_lowpass_filter_unit.f -----
design/llf_pkg.sv
design/llf_mul.sv
design/llf_ctrl.sv
design/llf_dpath.sv
design/ladder_lowpass_filter_unit.sv
design/llf_chk.sv
sim/tb_top.sv
